// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define PTW_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked at the same edge.
`define PTW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ptw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int ENTRY_W  = 64;
    localparam int VA_W     = 48;
    localparam int PA_W     = 52;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 3;
    localparam int IDX_W    = 9;
    localparam int WIDX_W   = 12;
    localparam int CFG_W    = 3;

    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd2;

    localparam logic REG_ROOT_TABLE  = 1'b0;
    localparam logic REG_START_LEVEL = 1'b1;

    localparam logic [CFG_W-1:0] ROOT_RESET  = 3'd0;
    localparam logic [CFG_W-1:0] LEVEL_RESET = 3'd4;

    localparam int PRESENT_BIT = 0;
    localparam int SIZE_BIT    = 7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_HOLD = 3'b100
    } walk_state_t;

    // 9-bit table index for a level: bits 12+9*(level-1) and up
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            3'd1:    idx = va[20:12];
            3'd2:    idx = va[29:21];
            3'd3:    idx = va[38:30];
            default: idx = va[47:39];
        endcase
        return idx;
    endfunction

    // frame bits of the leaf entry with the page offset merged in
    function automatic logic [PA_W-1:0] leaf_address(input logic [ENTRY_W-1:0] entry,
                                                     input logic [VA_W-1:0] va,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [PA_W-1:0] pa;
        unique case (lvl)
            3'd2:    pa = {entry[51:21], va[20:0]};
            3'd3:    pa = {entry[51:30], va[29:0]};
            default: pa = {entry[51:12], va[11:0]};
        endcase
        return pa;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ptw_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptw_store #(
    parameter int TABLE_COUNT = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   wr_en,
    input  wire logic [$clog2(TABLE_COUNT)+9-1:0]       wr_addr,
    input  wire logic [ptw_pkg::ENTRY_W-1:0]            wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [$clog2(TABLE_COUNT)+9-1:0]       rd_addr,
    output logic      [ptw_pkg::ENTRY_W-1:0]            rd_data,
    output logic                                        clr_busy
);
    import ptw_pkg::*;

    localparam int TW    = $clog2(TABLE_COUNT);
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = TABLE_COUNT * 512;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // sweep zeros through the store after reset, then take walker writes
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

`include "assert_macros.svh"

    `PTW_ASSERT(a_no_write_during_clear, !(clr_busy_reg && wr_en), "write during clearing pass")
    `PTW_ASSERT_IMPL(a_no_read_during_clear, clr_busy_reg, !rd_en, "read during clearing pass")

endmodule

`default_nettype wire

// ----- hw/rtl/ptw_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptw_walker #(
    parameter int TABLE_COUNT = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [ptw_pkg::CFG_W-1:0]              root_table,
    input  wire logic [ptw_pkg::CFG_W-1:0]              start_level,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   operation,
    input  wire logic [ptw_pkg::WIDX_W-1:0]             entry_index,
    input  wire logic [ptw_pkg::ENTRY_W-1:0]            entry_value,
    input  wire logic [ptw_pkg::VA_W-1:0]               virtual_address,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic      [ptw_pkg::PA_W-1:0]               physical_address,
    output logic      [ptw_pkg::STATUS_W-1:0]           status,
    output logic      [ptw_pkg::LEVEL_W-1:0]            leaf_level,
    input  wire logic                                   clr_busy,
    output logic                                        mem_wr_en,
    output logic      [$clog2(TABLE_COUNT)+9-1:0]       mem_wr_addr,
    output logic      [ptw_pkg::ENTRY_W-1:0]            mem_wr_data,
    output logic                                        mem_rd_en,
    output logic      [$clog2(TABLE_COUNT)+9-1:0]       mem_rd_addr,
    input  wire logic [ptw_pkg::ENTRY_W-1:0]            mem_rd_data
);
    import ptw_pkg::*;

    localparam int TW      = $clog2(TABLE_COUNT);
    localparam int AW      = TW + IDX_W;
    localparam int WIDE_W  = 16;
    localparam int FRAME_W = PA_W - 12;

    walk_state_t         state_reg, state_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [LEVEL_W-1:0]  lvl_reg, lvl_next;
    logic [PA_W-1:0]     hold_pa_reg, hold_pa_next;
    logic [STATUS_W-1:0] hold_status_reg, hold_status_next;
    logic [LEVEL_W-1:0]  hold_level_reg, hold_level_next;
    logic                out_valid_reg, out_valid_next;
    logic [PA_W-1:0]     out_pa_reg, out_pa_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;

    logic                accept;
    logic                slot_free;
    logic                done;
    logic [PA_W-1:0]     res_pa;
    logic [STATUS_W-1:0] res_status;
    logic [LEVEL_W-1:0]  res_level;
    logic [LEVEL_W-1:0]  first_level;
    logic [6:0]          root_wide;
    logic                root_outside;
    logic [WIDE_W-1:0]   wr_word;
    logic                wr_in_range;
    logic [FRAME_W-1:0]  next_frame;
    logic                entry_present;
    logic                entry_leaf;
    logic                frame_outside;

    assign in_ready  = (state_reg == ST_IDLE) && !clr_busy;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // clamp the start level into 1..4
    assign first_level = (start_level == 3'd0) ? 3'd1 :
                         (start_level > 3'd4)  ? 3'd4 : start_level;
    assign root_wide    = {4'b0, root_table};
    assign root_outside = root_wide >= 7'(TABLE_COUNT);

    assign wr_word     = {{(WIDE_W - WIDX_W){1'b0}}, entry_index};
    assign wr_in_range = wr_word < WIDE_W'(TABLE_COUNT * 512);
    assign mem_wr_addr = wr_word[AW-1:0];
    assign mem_wr_data = entry_value;

    assign next_frame    = mem_rd_data[PA_W-1:12];
    assign entry_present = mem_rd_data[PRESENT_BIT];
    assign entry_leaf    = (lvl_reg == 3'd1) || ((lvl_reg != 3'd4) && mem_rd_data[SIZE_BIT]);
    assign frame_outside = next_frame >= FRAME_W'(TABLE_COUNT);

    always_comb begin
        state_next       = state_reg;
        va_next          = va_reg;
        lvl_next         = lvl_reg;
        hold_pa_next     = hold_pa_reg;
        hold_status_next = hold_status_reg;
        hold_level_next  = hold_level_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_pa_next      = out_pa_reg;
        out_status_next  = out_status_reg;
        out_level_next   = out_level_reg;
        done             = 1'b0;
        res_pa           = '0;
        res_status       = STATUS_OK;
        res_level        = '0;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_WRITE)
                    begin
                        mem_wr_en = wr_in_range;
                        done      = 1'b1;
                    end
                    else
                    begin
                        va_next  = virtual_address;
                        lvl_next = first_level;
                        if (root_outside)
                        begin
                            done       = 1'b1;
                            res_status = STATUS_OUTSIDE;
                            res_level  = first_level;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = {root_wide[TW-1:0],
                                           level_index(virtual_address, first_level)};
                            state_next  = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                // entry of the current level is on the read port
                if (!entry_present)
                begin
                    done       = 1'b1;
                    res_status = STATUS_ABSENT;
                    res_level  = lvl_reg;
                end
                else if (entry_leaf)
                begin
                    done      = 1'b1;
                    res_pa    = leaf_address(mem_rd_data, va_reg, lvl_reg);
                    res_level = lvl_reg;
                end
                else if (frame_outside)
                begin
                    done       = 1'b1;
                    res_status = STATUS_OUTSIDE;
                    res_level  = lvl_reg;
                end
                else
                begin
                    lvl_next    = lvl_reg - 3'd1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = {next_frame[TW-1:0], level_index(va_reg, lvl_reg - 3'd1)};
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pa_next     = hold_pa_reg;
                    out_status_next = hold_status_reg;
                    out_level_next  = hold_level_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // hand the result to the output word, or park it until the slot drains
        if (done)
        begin
            if (slot_free)
            begin
                out_valid_next  = 1'b1;
                out_pa_next     = res_pa;
                out_status_next = res_status;
                out_level_next  = res_level;
                state_next      = ST_IDLE;
            end
            else
            begin
                hold_pa_next     = res_pa;
                hold_status_next = res_status;
                hold_level_next  = res_level;
                state_next       = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg          <= va_next;
        lvl_reg         <= lvl_next;
        hold_pa_reg     <= hold_pa_next;
        hold_status_reg <= hold_status_next;
        hold_level_reg  <= hold_level_next;
        out_pa_reg      <= out_pa_next;
        out_status_reg  <= out_status_next;
        out_level_reg   <= out_level_next;
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = out_pa_reg;
    assign status           = out_status_reg;
    assign leaf_level       = out_level_reg;

`include "assert_macros.svh"

    `PTW_ASSERT_IMPL(a_hold_means_full, state_reg == ST_HOLD, out_valid_reg, "parked result with empty output")
    `PTW_ASSERT_IMPL(a_walk_level, state_reg == ST_WALK, (lvl_reg >= 3'd1) && (lvl_reg <= 3'd4), "walk level out of range")
    `PTW_ASSERT_IMPL(a_read_only_when_walking, mem_rd_en, !mem_wr_en, "store read and write together")

endmodule

`default_nettype wire

// ----- hw/rtl/page_table_walk_translate.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Content
// s_*       in         tuser: operation; tdata: entry_index, entry_value, virtual_address
// m_*       out        tdata: physical_address, status, leaf_level
// cfg_*     in         cfg_index: 0 root_table, 1 start_level; cfg_data: value
//
// A write word goes to the store when it is taken; a translate word issues one
// store read per level walked (up to 4), the first when it is taken, paced by
// the single read port of the table store. One word is in the walker at a time.
// After reset a clearing pass zeroes all TABLE_COUNT*512 store words with
// s_tready low; cfg writes are taken at all times.
// A finished result waits in the output register, and a second one parks in the
// walker, while m_tready is low.

module page_table_walk_translate #(
    parameter int TABLE_COUNT = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // entry_index[11:0], entry_value[75:12], virtual_address[123:76]
    input  wire logic          s_tuser,   // operation[0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [63:0]   m_tdata,   // physical_address[51:0], status[53:52], leaf_level[56:54]
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [2:0]    cfg_data
);
    import ptw_pkg::*;

    localparam int AW = $clog2(TABLE_COUNT) + IDX_W;

    logic [CFG_W-1:0]    root_table_reg, root_table_next;
    logic [CFG_W-1:0]    start_level_reg, start_level_next;
    logic [PA_W-1:0]     physical_address;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  leaf_level;
    logic                clr_busy;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [ENTRY_W-1:0]  mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [ENTRY_W-1:0]  mem_rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        root_table_next  = root_table_reg;
        start_level_next = start_level_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROOT_TABLE:  root_table_next  = cfg_data;
                REG_START_LEVEL: start_level_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_table_reg  <= ROOT_RESET;
            start_level_reg <= LEVEL_RESET;
        end
        else
        begin
            root_table_reg  <= root_table_next;
            start_level_reg <= start_level_next;
        end
    end

    ptw_walker #(
        .TABLE_COUNT (TABLE_COUNT)
    ) u_walker (
        .clk              (clk),
        .rst_n            (rst_n),
        .root_table       (root_table_reg),
        .start_level      (start_level_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .operation        (s_tuser),
        .entry_index      (s_tdata[11:0]),
        .entry_value      (s_tdata[75:12]),
        .virtual_address  (s_tdata[123:76]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .physical_address (physical_address),
        .status           (status),
        .leaf_level       (leaf_level),
        .clr_busy         (clr_busy),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data)
    );

    ptw_store #(
        .TABLE_COUNT (TABLE_COUNT)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .clr_busy (clr_busy)
    );

    assign m_tdata = {7'b0, leaf_level, status, physical_address};

endmodule

`default_nettype wire

// ----- sim/page_table_walk_translate_tb.sv -----
`timescale 1ns / 1ps

module page_table_walk_translate_tb;

    import ptw_pkg::*;

    localparam int TABLE_COUNT = 8;
    localparam int STORE_WORDS = TABLE_COUNT * 512;

    typedef struct packed {
        logic [PA_W-1:0]     pa;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
    } walk_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // entry_index[11:0], entry_value[75:12], virtual_address[123:76]
    logic         s_tuser = 1'b0; // operation[0]
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [63:0]  m_tdata;        // physical_address[51:0], status[53:52], leaf_level[56:54]
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [2:0]   cfg_data = '0;

    // walker model state
    logic [ENTRY_W-1:0] page_store [0:STORE_WORDS-1];
    logic [CFG_W-1:0]   walk_root = ROOT_RESET;
    logic [CFG_W-1:0]   walk_start = LEVEL_RESET;

    walk_result_t walk_results_due [$];
    int  words_sent = 0;
    int  mismatch_count = 0;
    int  hold_cycles = 0;
    bit  send_gaps = 1'b1;
    bit  recv_gaps = 1'b1;

    page_table_walk_translate #(
        .TABLE_COUNT(TABLE_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("page_table_walk_translate regression: fail");
        $finish;
    end

    initial
    begin
        foreach (page_store[i])
        begin
            page_store[i] = '0;
        end
    end

    function automatic int effective_level(input logic [CFG_W-1:0] raw);
        int lvl;
        lvl = raw;
        if (lvl < 1)
        begin
            lvl = 1;
        end
        if (lvl > 4)
        begin
            lvl = 4;
        end
        return lvl;
    endfunction

    function automatic walk_result_t predict_walk(input logic op,
                                                  input logic [WIDX_W-1:0] widx,
                                                  input logic [ENTRY_W-1:0] value,
                                                  input logic [VA_W-1:0] va);
        walk_result_t       res;
        int                 lvl;
        int                 shift;
        bit                 done;
        logic [39:0]        tbl;
        logic [ENTRY_W-1:0] pte;
        logic [PA_W-1:0]    offset_mask;
        res = '0;
        if (op == OP_WRITE)
        begin
            if (widx < STORE_WORDS)
            begin
                page_store[widx] = value;
            end
            return res;
        end
        lvl = effective_level(walk_start);
        tbl = 40'(walk_root);
        res.level = 3'(lvl);
        done = 1'b0;
        if (tbl >= TABLE_COUNT)
        begin
            res.status = STATUS_OUTSIDE;
            done = 1'b1;
        end
        while (!done)
        begin
            shift = 12 + 9 * (lvl - 1);
            pte = page_store[int'(tbl) * 512 + int'(9'(va >> shift))];
            res.level = 3'(lvl);
            if (!pte[PRESENT_BIT])
            begin
                res.status = STATUS_ABSENT;
                done = 1'b1;
            end
            else if (lvl == 1 || (lvl < 4 && pte[SIZE_BIT]))
            begin
                offset_mask = (52'd1 << shift) - 52'd1;
                res.pa = (pte[PA_W-1:0] & ~offset_mask) | ({4'b0, va} & offset_mask);
                done = 1'b1;
            end
            else
            begin
                tbl = pte[51:12];
                if (tbl >= TABLE_COUNT)
                begin
                    res.status = STATUS_OUTSIDE;
                    done = 1'b1;
                end
                else
                begin
                    lvl--;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // enter and leave at a falling edge
    task automatic send_word(input logic op, input logic [WIDX_W-1:0] widx,
                             input logic [ENTRY_W-1:0] value, input logic [VA_W-1:0] va);
        walk_result_t due;
        if (send_gaps && $urandom_range(99) < 9)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {4'b0, va, value, widx};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        due = predict_walk(op, widx, value, va);
        @(negedge clk);
        walk_results_due.push_back(due);
        words_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid = 1'b0;
        while (walk_results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [CFG_W-1:0] value);
        cfg_index = reg_sel;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (reg_sel == REG_ROOT_TABLE)
        begin
            walk_root = value;
        end
        else
        begin
            walk_start = value;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_walk_config(input logic [CFG_W-1:0] root, input logic [CFG_W-1:0] start);
        wait_results_done();
        write_register(REG_ROOT_TABLE, root);
        write_register(REG_START_LEVEL, start);
    endtask

    // write a path of entries from the root down to a leaf, then translate through it
    task automatic send_mapped_walk(input logic [VA_W-1:0] va, input int leaf_req,
                                    input bit spoil);
        int                 top;
        int                 leaf;
        int                 lvl;
        int                 bad_lvl;
        int                 shift;
        logic [2:0]         tbl;
        logic [2:0]         next_tbl;
        logic [ENTRY_W-1:0] pte;
        logic [VA_W-1:0]    offset_mask;
        logic [VA_W-1:0]    probe;
        top = effective_level(walk_start);
        leaf = (leaf_req > top) ? top : leaf_req;
        if (leaf > 3)
        begin
            leaf = 3;
        end
        bad_lvl = spoil ? $urandom_range(top, leaf) : 0;
        tbl = walk_root;
        for (lvl = top; lvl >= leaf; lvl--)
        begin
            shift = 12 + 9 * (lvl - 1);
            pte = {$urandom, $urandom};
            pte[PRESENT_BIT] = 1'b1;
            next_tbl = 3'($urandom_range(7));
            if (lvl == leaf)
            begin
                if (lvl > 1)
                begin
                    pte[SIZE_BIT] = 1'b1;
                end
            end
            else
            begin
                pte[51:12] = 40'(next_tbl);
                // level four keeps a random size bit, it must be ignored
                if (lvl < 4)
                begin
                    pte[SIZE_BIT] = 1'b0;
                end
            end
            if (lvl == bad_lvl)
            begin
                if (lvl == leaf || $urandom_range(1) == 0)
                begin
                    pte[PRESENT_BIT] = 1'b0;
                end
                else
                begin
                    // push the next-table frame past the store
                    pte[51:12] = 40'({$urandom, $urandom});
                    pte[15] = 1'b1;
                end
            end
            send_word(OP_WRITE, {tbl, 9'(va >> shift)}, pte, 48'({$urandom, $urandom}));
            tbl = next_tbl;
        end
        offset_mask = (48'd1 << (12 + 9 * (leaf - 1))) - 48'd1;
        repeat ($urandom_range(1, 3))
        begin
            probe = (va & ~offset_mask) | (48'({$urandom, $urandom}) & offset_mask);
            send_word(OP_TRANSLATE, 12'($urandom), {$urandom, $urandom}, probe);
        end
    endtask

    task automatic check_result(input logic [63:0] word);
        walk_result_t due;
        if (walk_results_due.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending, tdata %h", word));
            return;
        end
        due = walk_results_due.pop_front();
        if (word[51:0] !== due.pa)
        begin
            report_mismatch($sformatf("physical_address %h, want %h", word[51:0], due.pa));
        end
        if (word[53:52] !== due.status)
        begin
            report_mismatch($sformatf("status %0d, want %0d", word[53:52], due.status));
        end
        if (word[56:54] !== due.level)
        begin
            report_mismatch($sformatf("leaf_level %0d, want %0d", word[56:54], due.level));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_result(m_tdata);
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            m_tready = !(recv_gaps && $urandom_range(99) < 9);
        end
    end

    task automatic test_reset_defaults();
        send_word(OP_TRANSLATE, '0, '0, '0);
        send_word(OP_TRANSLATE, '1, '1, 48'({$urandom, $urandom}));
    endtask

    // one chain down the all-ones address, reshaped entry by entry
    task automatic test_directed_walks();
        send_word(OP_WRITE, 12'd4095, '1, '0);
        send_word(OP_WRITE, 12'd0, '0, '1);
        // top level: size bit and high bits set, still names table 1
        send_word(OP_WRITE, 12'd511, {12'hFFF, 40'd1, 12'h081}, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
        send_word(OP_WRITE, 12'd1023, '1, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
        send_word(OP_WRITE, 12'd1023, {12'h000, 40'd2, 12'h001}, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
        send_word(OP_WRITE, 12'd1535, {12'h000, 40'h55_5555_5555, 12'h081}, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
        send_word(OP_WRITE, 12'd1535, {12'h000, 40'd7, 12'h001}, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
        send_word(OP_TRANSLATE, '0, '0, {9'h1FF, 39'h0});
        send_word(OP_WRITE, 12'd1535, {12'h000, 40'd8, 12'h001}, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
        send_word(OP_WRITE, 12'd1535, {12'h000, 40'hFF_FFFF_FFFF, 12'h001}, '0);
        send_word(OP_TRANSLATE, '0, '0, '1);
    endtask

    task automatic test_level_and_root_settings();
        logic [CFG_W-1:0] roots [8]  = '{3'd7, 3'd0, 3'd3, 3'd7, 3'd0, 3'd5, 3'd2, 3'd0};
        logic [CFG_W-1:0] levels [8] = '{3'd0, 3'd5, 3'd7, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4};
        foreach (roots[i])
        begin
            set_walk_config(roots[i], levels[i]);
            repeat (3)
            begin
                send_mapped_walk(48'({$urandom, $urandom}), $urandom_range(1, 3), 1'b0);
            end
            send_mapped_walk(48'({$urandom, $urandom}), $urandom_range(1, 3), 1'b1);
        end
    endtask

    task automatic test_output_backpressure();
        wait_results_done();
        hold_cycles = 400;
        repeat (4)
        begin
            send_mapped_walk(48'({$urandom, $urandom}), $urandom_range(1, 3), 1'b0);
        end
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        int next_setting;
        int pick;
        next_setting = words_sent + 120;
        while (words_sent < 650)
        begin
            if (words_sent >= next_setting)
            begin
                set_walk_config(3'($urandom_range(7)), 3'($urandom_range(7)));
                next_setting = words_sent + 120;
            end
            // run flat out for a while on both sides
            send_gaps = (words_sent < 400 || words_sent >= 550);
            recv_gaps = send_gaps;
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_mapped_walk(48'({$urandom, $urandom}), $urandom_range(1, 3),
                                 $urandom_range(99) < 20);
            end
            else if (pick < 85)
            begin
                send_word(OP_WRITE, 12'($urandom), {$urandom, $urandom},
                          48'({$urandom, $urandom}));
            end
            else
            begin
                send_word(OP_TRANSLATE, 12'($urandom), {$urandom, $urandom},
                          48'({$urandom, $urandom}));
            end
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed_walks();
        test_level_and_root_settings();
        test_output_backpressure();
        test_random_traffic();
        wait_results_done();
        repeat (24) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("page_table_walk_translate regression: pass");
        end
        else
        begin
            $display("page_table_walk_translate regression: fail");
        end
        $finish;
    end

endmodule
